>>> rtl/pdu_pkg.sv
`default_nettype none

package pdu_pkg;

  // group geometry of the packed stream
  localparam int CODE_BITS       = 11;
  localparam int CODES_PER_GROUP = 8;
  localparam int BYTES_PER_GROUP = 11;
  localparam int GROUP_BITS      = CODE_BITS * CODES_PER_GROUP;
  localparam int BYTE_CNT_W      = 4;

  // lookup table geometry
  localparam int TABLE_ENTRIES = 2048;
  localparam int DEPTH_W       = 16;

  // request kinds
  typedef enum logic {
    OP_DATA     = 1'b0,
    OP_TABLE_WR = 1'b1
  } pdu_op_t;

endpackage

`default_nettype wire

>>> rtl/pdu_ram.sv
`default_nettype none

module pdu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/packed_depth_unpack_lut.sv
// channel   handshake                 payload
// in_       in_valid / in_stall       opcode, data_byte, frame_start, table_index, table_value
// out_      out_valid / out_stall     depth_value, last_of_group
//
// one request per cycle while in_stall is low; the eleventh byte of a group loads
// eight codes that are looked up one a cycle, while the output queue has room,
// through the single read port of the table ram, so a group yields its eight results,
// the first of them passing the code buffer, the ram read and the output queue in turn.
// a completing byte or a table write stalls while the previous group is still
// being looked up. reset (rst_n, synchronous) clears the byte count, the code
// buffer and the output queue; the table and partial group are not cleared.
// out_stall holds results in a two-entry output queue and throttles lookups.

`default_nettype none

module packed_depth_unpack_lut #(
  parameter int TABLE_ENTRIES = pdu_pkg::TABLE_ENTRIES
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_opcode,
  input  wire logic [7:0]                       in_data_byte,
  input  wire logic                             in_frame_start,
  input  wire logic [$clog2(TABLE_ENTRIES)-1:0] in_table_index,
  input  wire logic [pdu_pkg::DEPTH_W-1:0]      in_table_value,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [pdu_pkg::DEPTH_W-1:0]      out_depth_value,
  output logic                                  out_last_of_group
);

  import pdu_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_ENTRIES);

  logic                  in_acc;
  logic                  is_wr;
  logic [BYTE_CNT_W-1:0] cnt_eff;
  logic                  completes;
  logic                  busy;
  logic                  iss;
  logic                  pop;
  logic [2:0]            room_used;
  logic [GROUP_BITS-1:0] grp_load;
  logic [DEPTH_W-1:0]    rd_data;

  logic [BYTE_CNT_W-1:0] cnt_r;
  logic [7:0]            gb_r [BYTES_PER_GROUP-1];
  logic [GROUP_BITS-1:0] grp_r;
  logic [3:0]            left_r;
  logic                  infl_r;
  logic                  infl_last_r;
  logic [DEPTH_W-1:0]    fq_data_r [2];
  logic                  fq_last_r [2];
  logic                  fq_wp_r;
  logic                  fq_rp_r;
  logic [1:0]            fq_cnt_r;

  // request decode and interlock
  always_comb begin
    is_wr     = (in_opcode == OP_TABLE_WR);
    cnt_eff   = in_frame_start ? '0 : cnt_r;
    completes = !is_wr && (cnt_eff == BYTE_CNT_W'(BYTES_PER_GROUP - 1));
    busy      = (left_r != 4'd0);
    in_stall  = busy && (is_wr || completes);
    in_acc    = in_valid && !in_stall;
  end

  // full group word, first byte most significant
  always_comb begin
    for (int i = 0; i < BYTES_PER_GROUP - 1; i++) begin
      grp_load[GROUP_BITS-1-8*i -: 8] = gb_r[i];
    end
    grp_load[7:0] = in_data_byte;
  end

  // lookup issue, limited by space left in the output queue
  always_comb begin
    pop       = out_valid && !out_stall;
    room_used = 3'(fq_cnt_r) - 3'(pop) + 3'(infl_r);
    iss       = busy && (room_used < 3'd2);
  end

  // table ram
  pdu_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (in_acc && is_wr),
    .wr_addr (in_table_index),
    .wr_data (in_table_value),
    .rd_en   (iss),
    .rd_addr (grp_r[GROUP_BITS-1 -: ADDR_W]),
    .rd_data (rd_data)
  );

  // partial group bytes
  always_ff @(posedge clk) begin
    if (in_acc && !is_wr && !completes) begin
      gb_r[cnt_eff] <= in_data_byte;
    end
  end

  // byte count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_acc && !is_wr) begin
      cnt_r <= completes ? '0 : cnt_eff + 1'b1;
    end
  end

  // code buffer: load on group completion, shift out one code per lookup
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (in_acc && completes) begin
      left_r <= 4'(CODES_PER_GROUP);
    end else if (iss) begin
      left_r <= left_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && completes) begin
      grp_r <= grp_load;
    end else if (iss) begin
      grp_r <= grp_r << CODE_BITS;
    end
  end

  // lookups in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      infl_r      <= 1'b0;
      infl_last_r <= 1'b0;
    end else begin
      infl_r      <= iss;
      infl_last_r <= iss && (left_r == 4'd1);
    end
  end

  // output queue
  always_ff @(posedge clk) begin
    if (infl_r) begin
      fq_data_r[fq_wp_r] <= rd_data;
      fq_last_r[fq_wp_r] <= infl_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fq_wp_r  <= 1'b0;
      fq_rp_r  <= 1'b0;
      fq_cnt_r <= '0;
    end else begin
      if (infl_r) begin
        fq_wp_r <= !fq_wp_r;
      end
      if (pop) begin
        fq_rp_r <= !fq_rp_r;
      end
      fq_cnt_r <= fq_cnt_r + 2'(infl_r) - 2'(pop);
    end
  end

  assign out_valid         = (fq_cnt_r != 2'd0);
  assign out_depth_value   = fq_data_r[fq_rp_r];
  assign out_last_of_group = fq_last_r[fq_rp_r];

endmodule

`default_nettype wire
